/* rtl/jtl_pkg.sv */
// Shared types and constants of the JSON token lexer.
package jtl_pkg;

  localparam int unsigned MAX_BYTES_DEF = 1048576;
  localparam int unsigned TOKEN_POS_W   = 21;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned WORD_W        = 40;

  localparam logic [KIND_W-1:0] KIND_STRING   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PROPERTY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COMMENT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_KEYWORD  = 3'd4;

  // keywords packed first character in the low byte
  localparam logic [WORD_W-1:0] KW_TRUE  = 40'h00_65_75_72_74;
  localparam logic [WORD_W-1:0] KW_NULL  = 40'h00_6c_6c_75_6e;
  localparam logic [WORD_W-1:0] KW_FALSE = 40'h65_73_6c_61_66;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_SLASH      = 4'd1,
    M_MINUS      = 4'd2,
    M_STR        = 4'd3,
    M_STR_ESC    = 4'd4,
    M_STR_DONE   = 4'd5,
    M_LINE       = 4'd6,
    M_BLOCK      = 4'd7,
    M_BLOCK_STAR = 4'd8,
    M_NUM        = 4'd9,
    M_WORD       = 4'd10
  } mode_e;

  typedef struct packed {
    logic [TOKEN_POS_W-1:0] token_begin;
    logic [TOKEN_POS_W-1:0] token_end;
    logic [KIND_W-1:0]      token_kind;
    logic                   run_last;
  } token_t;

endpackage

/* rtl/jtl_if.sv */
// Valid/ready channels for text bytes in and tokens out.
interface jtl_byte_if;
  import jtl_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jtl_token_if;
  import jtl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TOKEN_POS_W-1:0] token_begin;
  logic [TOKEN_POS_W-1:0] token_end;
  logic [KIND_W-1:0]      token_kind;
  logic                   run_last;

  modport source (output valid, output token_begin, output token_end, output token_kind,
                  output run_last, input ready);
  modport sink   (input valid, input token_begin, input token_end, input token_kind,
                  input run_last, output ready);
endinterface

/* rtl/json_token_lexer.sv */
// JSON lexer with comments: one byte per cycle in while byte_i.ready is high, tokens out through a 4-entry queue.
// A token is registered into the output queue when the byte that closes it is accepted.
// A byte can close two tokens; each leaves the queue on its own output handshake.
// byte_i.ready is high while at most two tokens wait in the output queue.
// Reset (rst_ni low, async) empties the queue and returns the lexer to position 0.
module json_token_lexer #(
  parameter int unsigned MaxBytes = jtl_pkg::MAX_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  jtl_byte_if.sink           byte_i,
  jtl_token_if.source        token_o
);
  import jtl_pkg::*;

  localparam int unsigned POS_W = $clog2(MaxBytes + 1);
  localparam int unsigned EXT_W = (POS_W > TOKEN_POS_W) ? POS_W : TOKEN_POS_W;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MaxBytes);

  // lexer state
  mode_e             mode_q, mode_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  start_q, start_d;
  logic [POS_W-1:0]  close_q, close_d;
  logic [WORD_W-1:0] wchars_q, wchars_d;
  logic [2:0]        wlen_q, wlen_d;
  logic              wlong_q, wlong_d;

  // output queue
  token_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  logic              accept, pop;
  logic [7:0]        c;
  logic [POS_W-1:0]  nxt;
  logic              fresh;
  logic              e0_v, e1_v, e0_ok, e1_ok;
  logic [POS_W-1:0]  e0_b, e0_e, e1_b, e1_e;
  logic [KIND_W-1:0] e0_k, e1_k;
  token_t            r0, r1;
  logic [1:0]        push_n;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic word_start(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a) ||
           ch == 8'h5f || ch[7];
  endfunction

  function automatic logic num_char(input logic [7:0] ch);
    return is_digit(ch) || ch == CH_DOT || ch == 8'h65 || ch == 8'h45 ||
           ch == CH_PLUS || ch == CH_MINUS;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_CR;
  endfunction

  function automatic logic is_keyword(input logic [WORD_W-1:0] w, input logic [2:0] n,
                                      input logic ovl);
    return !ovl && ((n == 3'd4 && (w == KW_TRUE || w == KW_NULL)) ||
                    (n == 3'd5 && w == KW_FALSE));
  endfunction

  function automatic logic [TOKEN_POS_W-1:0] to_tok(input logic [POS_W-1:0] p);
    logic [EXT_W-1:0] t;
    t = EXT_W'(p);
    return t[TOKEN_POS_W-1:0];
  endfunction

  assign c      = byte_i.text_byte;
  assign accept = byte_i.valid && byte_i.ready;
  assign pop    = token_o.valid && token_o.ready;
  assign nxt    = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : POS_MAX;

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    close_d  = close_q;
    wchars_d = wchars_q;
    wlen_d   = wlen_q;
    wlong_d  = wlong_q;
    fresh    = 1'b0;
    e0_v     = 1'b0;
    e0_b     = start_q;
    e0_e     = pos_q;
    e0_k     = KIND_STRING;
    e1_v     = 1'b0;
    e1_e     = nxt;
    e1_k     = KIND_STRING;

    unique case (mode_q)
      M_SLASH: begin
        if (c == CH_SLASH) mode_d = M_LINE;
        else if (c == CH_STAR) mode_d = M_BLOCK;
        else fresh = 1'b1;
      end
      M_MINUS: begin
        if (is_digit(c)) mode_d = M_NUM;
        else fresh = 1'b1;
      end
      M_STR: begin
        if (c == CH_BSLASH) begin
          mode_d = M_STR_ESC;
        end else if (c == CH_QUOTE) begin
          close_d = nxt;
          mode_d  = M_STR_DONE;
        end else if (c == CH_LF) begin
          close_d = pos_q;
          mode_d  = M_STR_DONE;
        end
      end
      M_STR_ESC: mode_d = M_STR;
      M_STR_DONE: begin
        if (!is_blank(c)) begin
          e0_v = 1'b1;
          e0_e = close_q;
          if (c == CH_COLON) begin
            e0_k   = KIND_PROPERTY;
            mode_d = M_IDLE;
          end else begin
            e0_k  = KIND_STRING;
            fresh = 1'b1;
          end
        end
      end
      M_LINE: begin
        if (c == CH_LF) begin
          e0_v   = 1'b1;
          e0_k   = KIND_COMMENT;
          mode_d = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (c == CH_STAR) mode_d = M_BLOCK_STAR;
      end
      M_BLOCK_STAR: begin
        if (c == CH_SLASH) begin
          e0_v   = 1'b1;
          e0_e   = nxt;
          e0_k   = KIND_COMMENT;
          mode_d = M_IDLE;
        end else if (c != CH_STAR) begin
          mode_d = M_BLOCK;
        end
      end
      M_NUM: begin
        if (!num_char(c)) begin
          e0_v  = 1'b1;
          e0_k  = KIND_NUMBER;
          fresh = 1'b1;
        end
      end
      M_WORD: begin
        if (word_start(c) || is_digit(c)) begin
          if (wlen_q < 3'd5) begin
            wchars_d = wchars_q | (WORD_W'(c) << {wlen_q, 3'b000});
            wlen_d   = wlen_q + 3'd1;
          end else begin
            wlong_d = 1'b1;
          end
        end else begin
          e0_v  = is_keyword(wchars_q, wlen_q, wlong_q);
          e0_k  = KIND_KEYWORD;
          fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase

    if (fresh) begin
      start_d = pos_q;
      if (c == CH_QUOTE) mode_d = M_STR;
      else if (c == CH_SLASH) mode_d = M_SLASH;
      else if (is_digit(c)) mode_d = M_NUM;
      else if (c == CH_MINUS) mode_d = M_MINUS;
      else if (word_start(c)) begin
        mode_d   = M_WORD;
        wchars_d = WORD_W'(c);
        wlen_d   = 3'd1;
        wlong_d  = 1'b0;
      end else mode_d = M_IDLE;
    end

    // final byte: close an open string, comment, number or keyword, then start over at position 0
    e1_b  = start_d;
    pos_d = nxt;
    if (byte_i.end_of_text) begin
      unique case (mode_d)
        M_STR, M_STR_ESC: begin
          e1_v = 1'b1;
          e1_k = KIND_STRING;
        end
        M_STR_DONE: begin
          e1_v = 1'b1;
          e1_e = close_d;
          e1_k = KIND_STRING;
        end
        M_LINE, M_BLOCK, M_BLOCK_STAR: begin
          e1_v = 1'b1;
          e1_k = KIND_COMMENT;
        end
        M_NUM: begin
          e1_v = 1'b1;
          e1_k = KIND_NUMBER;
        end
        M_WORD: begin
          e1_v = is_keyword(wchars_d, wlen_d, wlong_d);
          e1_k = KIND_KEYWORD;
        end
        default: e1_v = 1'b0;
      endcase
      mode_d   = M_IDLE;
      pos_d    = '0;
      start_d  = '0;
      close_d  = '0;
      wchars_d = '0;
      wlen_d   = '0;
      wlong_d  = 1'b0;
    end
  end

  // empty tokens (end not past begin) are dropped
  assign e0_ok  = accept && e0_v && (e0_e > e0_b);
  assign e1_ok  = accept && e1_v && (e1_e > e1_b);
  assign push_n = {1'b0, e0_ok} + {1'b0, e1_ok};

  assign r0 = '{token_begin: to_tok(e0_b), token_end: to_tok(e0_e), token_kind: e0_k,
                run_last: !e1_ok};
  assign r1 = '{token_begin: to_tok(e1_b), token_end: to_tok(e1_e), token_kind: e1_k,
                run_last: 1'b1};

  assign cnt_d = cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '0;
      start_q  <= '0;
      close_q  <= '0;
      wchars_q <= '0;
      wlen_q   <= '0;
      wlong_q  <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      close_q  <= close_d;
      wchars_q <= wchars_d;
      wlen_q   <= wlen_d;
      wlong_q  <= wlong_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_W'(push_n);
      rd_q  <= rd_q + QPTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e0_ok) queue_q[wr_q] <= r0;
    if (e1_ok) queue_q[e0_ok ? wr_q + QPTR_W'(1) : wr_q] <= r1;
  end

  // room for the two tokens one byte can close
  assign byte_i.ready = cnt_q <= QCNT_W'(QDEPTH - 2);

  assign token_o.valid       = cnt_q != '0;
  assign token_o.token_begin = queue_q[rd_q].token_begin;
  assign token_o.token_end   = queue_q[rd_q].token_end;
  assign token_o.token_kind  = queue_q[rd_q].token_kind;
  assign token_o.run_last    = queue_q[rd_q].run_last;

endmodule
